FILE: sv/dbd_pkg.sv
// Shared types, constants and calendar tables for the days-between-dates block.
// No dependencies; every other file of the block imports this package.
`default_nettype none

package dbd_pkg;

    localparam int DATE_W   = 27;
    localparam int STATUS_W = 2;
    localparam int COUNT_W  = 23;
    localparam int DNUM_W   = 22;

    // Register stages inside one date unit, and in the whole pipeline.
    localparam int UNIT_STAGES = 5;
    localparam int PIPE_DEPTH  = UNIT_STAGES + 1;

    // Exact reciprocals: floor(x / 625) for x < 2**23 and floor(x / 25) for x < 2**12.
    localparam logic [23:0] RECIP_625  = 24'd13743896;
    localparam logic [15:0] RECIP_25   = 16'd41944;
    localparam logic [9:0]  DIV_625    = 10'd625;
    localparam logic [6:0]  CENTURY    = 7'd100;
    localparam logic [8:0]  YEAR_DAYS  = 9'd365;
    localparam logic [4:0]  LEAP_FEB   = 5'd29;
    localparam logic [3:0]  FEBRUARY   = 4'd2;
    localparam logic [3:0]  LAST_MONTH = 4'd12;
    localparam logic [4:0]  LAST_DAY   = 5'd31;

    typedef enum logic [STATUS_W-1:0] {
        ST_VALID,
        ST_BAD_DAY,
        ST_BAD_MONTH,
        ST_BAD_YEAR
    } date_status_t;

    typedef logic [UNIT_STAGES-1:0] stage_en_t;

    typedef struct packed {
        date_status_t        status;
        logic [DNUM_W-1:0]   day_num;
    } date_res_t;

    function automatic logic [4:0] month_length(input logic [3:0] m);
        logic [4:0] len;
        unique case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
            4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
            4'd2:                                       len = 5'd28;
            default:                                    len = 5'd0;
        endcase
        return len;
    endfunction

    function automatic logic [8:0] days_before_month(input logic [3:0] m);
        logic [8:0] days;
        unique case (m)
            4'd2:    days = 9'd31;
            4'd3:    days = 9'd59;
            4'd4:    days = 9'd90;
            4'd5:    days = 9'd120;
            4'd6:    days = 9'd151;
            4'd7:    days = 9'd181;
            4'd8:    days = 9'd212;
            4'd9:    days = 9'd243;
            4'd10:   days = 9'd273;
            4'd11:   days = 9'd304;
            4'd12:   days = 9'd334;
            default: days = 9'd0;
        endcase
        return days;
    endfunction

endpackage

`default_nettype wire

FILE: sv/dbd_in_if.sv
// Input channel: one word carries a pair of packed DDMMYYYY dates.
// Depends on dbd_pkg for the field widths.
`default_nettype none

interface dbd_in_if
    import dbd_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [DATE_W-1:0] first_packed_date;
    logic [DATE_W-1:0] second_packed_date;

    modport source (output valid, output first_packed_date, output second_packed_date,
                    input ready);
    modport sink   (input valid, input first_packed_date, input second_packed_date,
                    output ready);
endinterface

`default_nettype wire

FILE: sv/dbd_out_if.sv
// Output channel: one word carries both date statuses and the day count.
// Depends on dbd_pkg for the field widths.
`default_nettype none

interface dbd_out_if
    import dbd_pkg::*;
;
    logic                      valid;
    logic                      ready;
    logic [STATUS_W-1:0]       first_status;
    logic [STATUS_W-1:0]       second_status;
    logic signed [COUNT_W-1:0] day_count;

    modport source (output valid, output first_status, output second_status,
                    output day_count, input ready);
    modport sink   (input valid, input first_status, input second_status,
                    input day_count, output ready);
endinterface

`default_nettype wire

FILE: sv/days_between_dates.sv
// Days between two Gregorian dates.
//
// Each word on the dates channel holds two dates, each packed as the decimal
// number DDMMYYYY. The result channel returns, per word, a status for each date
// (valid, bad day, bad month, bad year) and the inclusive count of days from the
// first date to the second, which is zero unless both are valid.
//
// A word passes the registered stages A to E of the date units, then the output
// stage. Throughput is one word per cycle while result.ready is high, set by the
// six-stage pipeline with one register per stage and no shared unit. Stages that
// hold no word keep accepting while the receiver stalls, so the pipeline fills up
// to six words before dates.ready falls.
//
// Reset clears the valid bits of all stages; the channel is empty afterwards.
// Depends on dbd_pkg, dbd_in_if, dbd_out_if and dbd_date_unit.
`default_nettype none

module days_between_dates
    import dbd_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    dbd_in_if.sink    dates,
    dbd_out_if.source result
);

    logic [PIPE_DEPTH-1:0] valid_reg;
    logic [PIPE_DEPTH-1:0] stage_en;
    stage_en_t             unit_en;
    date_res_t             first_res;
    date_res_t             second_res;

    // A stage loads when it is empty or when its word moves on.
    always_comb
    begin
        stage_en[PIPE_DEPTH-1] = !valid_reg[PIPE_DEPTH-1] || result.ready;
        for (int i = PIPE_DEPTH - 2; i >= 0; i--)
        begin
            stage_en[i] = !valid_reg[i] || stage_en[i+1];
        end
        unit_en = stage_en[UNIT_STAGES-1:0];
    end

    assign dates.ready = stage_en[0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (stage_en[0])
            begin
                valid_reg[0] <= dates.valid;
            end
            for (int i = 1; i < PIPE_DEPTH; i++)
            begin
                if (stage_en[i])
                begin
                    valid_reg[i] <= valid_reg[i-1];
                end
            end
        end
    end

    dbd_date_unit u_first (
        .clk         (clk),
        .en          (unit_en),
        .packed_date (dates.first_packed_date),
        .res         (first_res)
    );

    dbd_date_unit u_second (
        .clk         (clk),
        .en          (unit_en),
        .packed_date (dates.second_packed_date),
        .res         (second_res)
    );

    // Output stage: difference of the day numbers, inclusive of both ends.
    logic                both_valid;
    logic [COUNT_W-1:0]  count_next;
    date_status_t        first_status_reg;
    date_status_t        second_status_reg;
    logic [COUNT_W-1:0]  count_reg;

    always_comb
    begin
        both_valid = (first_res.status == ST_VALID) && (second_res.status == ST_VALID);
        count_next = both_valid
                   ? COUNT_W'(second_res.day_num) - COUNT_W'(first_res.day_num) + COUNT_W'(1)
                   : '0;
    end

    always_ff @(posedge clk)
    begin
        if (stage_en[PIPE_DEPTH-1])
        begin
            first_status_reg  <= first_res.status;
            second_status_reg <= second_res.status;
            count_reg         <= count_next;
        end
    end

    assign result.valid         = valid_reg[PIPE_DEPTH-1];
    assign result.first_status  = first_status_reg;
    assign result.second_status = second_status_reg;
    assign result.day_count     = count_reg;

`ifndef SYNTHESIS
    // A date that failed its check never yields a nonzero count.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && ((result.first_status != ST_VALID) || (result.second_status != ST_VALID))
        |-> (result.day_count == '0))
        else $error("nonzero day count with an invalid date");

    // While some stage is empty the pipeline must take a new word.
    assert property (@(posedge clk) disable iff (!rst_n)
        (valid_reg != '1) |-> dates.ready)
        else $error("pipeline refused a word while a stage was empty");

    // Words in flight change only by what enters and what leaves.
    assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |->
        ($countones(valid_reg) == $countones($past(valid_reg))
            + ($past(dates.valid && dates.ready) ? 1 : 0)
            - ($past(result.valid && result.ready) ? 1 : 0)))
        else $error("word lost or duplicated in the pipeline");

    // A stalled result must not be overwritten by the stage behind it.
    assert property (@(posedge clk) disable iff (!rst_n)
        result.valid && !result.ready |=> result.valid && $stable(count_reg))
        else $error("stalled result was overwritten");
`endif

endmodule

`default_nettype wire

FILE: sv/dbd_date_unit.sv
// Five-stage datapath for one date: decimal split, validation and day number.
// Depends on dbd_pkg; stage enables come from the pipeline control in the top level.
`default_nettype none

module dbd_date_unit
    import dbd_pkg::*;
(
    input  logic              clk,
    input  stage_en_t         en,
    input  logic [DATE_W-1:0] packed_date,
    output date_res_t         res
);

    // Stage A: the packed value is 16*x + low, and x / 625 gives value / 10000.
    logic [22:0] a_x_reg;
    logic [3:0]  a_low_reg;
    logic [46:0] a_prod_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            a_x_reg    <= packed_date[DATE_W-1:4];
            a_low_reg  <= packed_date[3:0];
            a_prod_reg <= 47'(packed_date[DATE_W-1:4]) * 47'(RECIP_625);
        end
    end

    // Stage B: quotient by 10000 and the year; year = 16 * (x mod 625) + low.
    logic [13:0] b_quot;
    logic [22:0] b_rem_wide;
    logic [13:0] b_quot_reg;
    logic [13:0] b_year_reg;

    always_comb
    begin
        b_quot     = a_prod_reg[46:33];
        b_rem_wide = a_x_reg - 23'(b_quot) * 23'(DIV_625);
    end

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            b_quot_reg <= b_quot;
            b_year_reg <= {b_rem_wide[9:0], a_low_reg};
        end
    end

    // Stage C: the three divisions by 100 are started as (v / 4) / 25.
    logic [13:0] c_prev;
    logic [27:0] c_day_prod_reg;
    logic [27:0] c_y100_prod_reg;
    logic [27:0] c_p100_prod_reg;
    logic [13:0] c_quot_reg;
    logic [13:0] c_year_reg;
    logic [13:0] c_prev_reg;

    always_comb
    begin
        c_prev = b_year_reg - 14'd1;
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            c_day_prod_reg  <= 28'(b_quot_reg[13:2]) * 28'(RECIP_25);
            c_y100_prod_reg <= 28'(b_year_reg[13:2]) * 28'(RECIP_25);
            c_p100_prod_reg <= 28'(c_prev[13:2]) * 28'(RECIP_25);
            c_quot_reg      <= b_quot_reg;
            c_year_reg      <= b_year_reg;
            c_prev_reg      <= c_prev;
        end
    end

    // Stage D: day, month, leap year and the status of the date.
    logic [7:0]   d_day;
    logic [13:0]  d_month_wide;
    logic [6:0]   d_month;
    logic [7:0]   d_y100;
    logic [13:0]  d_rem100;
    logic         d_leap;
    logic [4:0]   d_limit;
    date_status_t d_status;
    date_status_t d_status_reg;
    logic [4:0]   d_day_reg;
    logic [3:0]   d_month_reg;
    logic         d_leap_reg;
    logic [13:0]  d_prev_reg;
    logic [7:0]   d_p100_reg;

    always_comb
    begin
        d_day        = c_day_prod_reg[27:20];
        d_month_wide = c_quot_reg - 14'(d_day) * 14'(CENTURY);
        d_month      = d_month_wide[6:0];
        d_y100       = c_y100_prod_reg[27:20];
        d_rem100     = c_year_reg - 14'(d_y100) * 14'(CENTURY);
        // Century years are leap only when the century count is a multiple of four.
        d_leap       = (d_rem100 == 14'd0) ? (d_y100[1:0] == 2'd0) : (c_year_reg[1:0] == 2'd0);
        d_limit      = month_length(d_month[3:0]);
        if ((d_month[3:0] == FEBRUARY) && d_leap)
        begin
            d_limit = LEAP_FEB;
        end
        priority if ((d_day == 8'd0) || (d_day > 8'(LAST_DAY)))
        begin
            d_status = ST_BAD_DAY;
        end
        else if ((d_month == 7'd0) || (d_month > 7'(LAST_MONTH)))
        begin
            d_status = ST_BAD_MONTH;
        end
        else if (c_year_reg == 14'd0)
        begin
            d_status = ST_BAD_YEAR;
        end
        else if (d_day[4:0] > d_limit)
        begin
            d_status = ST_BAD_DAY;
        end
        else
        begin
            d_status = ST_VALID;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[3])
        begin
            d_status_reg <= d_status;
            d_day_reg    <= d_day[4:0];
            d_month_reg  <= d_month[3:0];
            d_leap_reg   <= d_leap;
            d_prev_reg   <= c_prev_reg;
            d_p100_reg   <= c_p100_prod_reg[27:20];
        end
    end

    // Stage E: day number, counted from 1 January of year 1 as day 1.
    logic [DNUM_W-1:0] e_day_num;
    logic              e_leap_day;
    date_res_t         e_res_reg;

    always_comb
    begin
        e_leap_day = d_leap_reg && (d_month_reg > FEBRUARY);
        e_day_num  = DNUM_W'(d_prev_reg) * DNUM_W'(YEAR_DAYS)
                   + DNUM_W'(d_prev_reg[13:2])
                   - DNUM_W'(d_p100_reg)
                   + DNUM_W'(d_p100_reg[7:2])
                   + DNUM_W'(days_before_month(d_month_reg))
                   + DNUM_W'(e_leap_day)
                   + DNUM_W'(d_day_reg);
    end

    always_ff @(posedge clk)
    begin
        if (en[4])
        begin
            e_res_reg.status  <= d_status_reg;
            e_res_reg.day_num <= e_day_num;
        end
    end

    assign res = e_res_reg;

endmodule

`default_nettype wire
